### rtl/channel_dependency_cycle_check_top_macros.svh
// Assertion macros for the channel dependency cycle check.
`ifndef CHANNEL_DEPENDENCY_CYCLE_CHECK_TOP_MACROS_SVH
`define CHANNEL_DEPENDENCY_CYCLE_CHECK_TOP_MACROS_SVH

// Next-cycle implication, masked while reset is high.
`define CCC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ccc: next-cycle property failed");

// Next-cycle implication that also holds across reset.
`define CCC_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("ccc: reset property failed");

`endif

### rtl/ccc_pkg.sv
// Types, constants and helpers shared by the cycle check modules.
package ccc_pkg;

   localparam int NUM_LINKS   = 64;
   localparam int LINK_W      = 6;
   localparam int CUR_W       = 7;
   localparam int SP_W        = 7;
   localparam int STACK_DEPTH = 64;
   localparam int STK_AW      = 6;
   localparam int REQ_DW      = 8;
   localparam int REQ_UW      = 2;
   localparam int RSP_DW      = 8;

   typedef logic [LINK_W-1:0]    link_type;
   typedef logic [NUM_LINKS-1:0] row_type;
   typedef logic [CUR_W-1:0]     cur_type;
   typedef logic [SP_W-1:0]      sp_type;
   typedef logic [REQ_UW-1:0]    func_type;

   localparam func_type FUNC_LINK  = 2'd0;
   localparam func_type FUNC_END   = 2'd1;
   localparam func_type FUNC_CHECK = 2'd2;
   localparam func_type FUNC_CLEAR = 2'd3;

   typedef struct packed {
      link_type v;
      cur_type  c;
   } entry_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic edge_wr;
      logic walk_init;
      logic root;
      logic step;
      logic pop;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic need_edge;
      logic roots_done;
      logic rest_zero;
      logic hit;
      logic sp_last;
      logic rsp_full;
   } stat_type;

   function automatic link_type first_set(row_type x);
      link_type r;
      r = '0;
      for (int i = NUM_LINKS - 1; i >= 0; i--) begin
         if (x[i]) r = LINK_W'(i);
      end
      return r;
   endfunction

   function automatic row_type onehot(link_type i);
      return row_type'(1) << i;
   endfunction

endpackage

### rtl/ccc_ctrl.sv
// Sequencer for loads, clears and the depth-first cycle walk.
module ccc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  ccc_pkg::func_type req_func,
   input  logic              rsp_tready,
   input  ccc_pkg::stat_type stat,
   output ccc_pkg::cmd_type  cmd
);
   import ccc_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EDGE = 3'd1;
   localparam logic [2:0] ST_ROOT = 3'd2;
   localparam logic [2:0] ST_STEP = 3'd3;
   localparam logic [2:0] ST_POP  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_func)
                  FUNC_LINK, FUNC_END: begin
                     cmd.load = 1'b1;
                     if (stat.need_edge) state_in = ST_EDGE;
                  end
                  FUNC_CHECK: begin
                     cmd.walk_init = 1'b1;
                     state_in      = ST_ROOT;
                  end
                  FUNC_CLEAR: cmd.clear = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_EDGE: begin
            cmd.edge_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_ROOT: begin
            if (stat.roots_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.root = 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if (stat.rest_zero) begin
               state_in = stat.sp_last ? ST_ROOT : ST_POP;
            end else if (stat.hit) begin
               state_in = ST_DONE;
            end
         end
         ST_POP: begin
            cmd.pop  = 1'b1;
            state_in = ST_STEP;
         end
         ST_DONE: begin
            if (!stat.rsp_full || rsp_tready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

### rtl/ccc_dp.sv
// Datapath: edge matrix, route tracking, walk marks, walk stack and result register.
module ccc_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  ccc_pkg::link_type            req_link,
   input  ccc_pkg::func_type            req_func,
   input  ccc_pkg::cmd_type             cmd,
   input  logic                         rsp_tready,
   output ccc_pkg::stat_type            stat,
   output logic                         rsp_tvalid,
   output logic [ccc_pkg::RSP_DW-1:0]   rsp_tdata
);
   import ccc_pkg::*;

   row_type   edge_mem [NUM_LINKS];
   entry_type stack_mem [STACK_DEPTH];

   link_type  prev_link_ff;
   logic      prev_valid_ff;
   logic      sticky_ff;
   link_type  wr_row_ff;
   link_type  wr_bit_ff;
   row_type   row_vld_ff;
   row_type   edge_q_ff;
   logic      edge_vld_ff;
   row_type   visited_ff;
   row_type   on_path_ff;
   link_type  top_v_ff;
   cur_type   top_c_ff;
   sp_type    sp_ff;
   entry_type stk_q_ff;
   logic      cyc_ff;
   logic      rsp_valid_ff;
   logic      rsp_cyc_ff;
   logic      rsp_err_ff;

   logic      in_range;
   logic      same_link;
   logic      need_edge;
   row_type   row;
   row_type   rest;
   logic      rest_zero;
   link_type  w;
   cur_type   w_next;
   logic      hit;
   logic      push;
   row_type   unvisited;
   link_type  root;
   sp_type    sp_m1;
   sp_type    sp_m2;
   logic      rd_en;
   link_type  rd_addr;
   row_type   wr_data;
   logic      do_pop_rd;

   assign in_range  = ({1'b0, req_link} < (LINK_W + 1)'(NUM_LINKS));
   assign same_link = (prev_link_ff == req_link);
   assign need_edge = in_range && prev_valid_ff && !same_link;

   assign row = edge_q_ff & {NUM_LINKS{edge_vld_ff}};

   always_comb begin
      for (int i = 0; i < NUM_LINKS; i++) begin
         rest[i] = row[i] && (CUR_W'(i) >= top_c_ff);
      end
   end

   assign rest_zero = (rest == '0);
   assign w         = first_set(rest);
   assign w_next    = CUR_W'(w) + CUR_W'(1);
   assign hit       = on_path_ff[w];
   assign push      = !rest_zero && !hit && !visited_ff[w] && (sp_ff < SP_W'(STACK_DEPTH));
   assign unvisited = ~visited_ff;
   assign root      = first_set(unvisited);
   assign sp_m1     = sp_ff - SP_W'(1);
   assign sp_m2     = sp_ff - SP_W'(2);
   assign do_pop_rd = cmd.step && rest_zero && (sp_ff != SP_W'(1));

   assign stat.need_edge  = need_edge;
   assign stat.roots_done = (unvisited == '0);
   assign stat.rest_zero  = rest_zero;
   assign stat.hit        = hit;
   assign stat.sp_last    = (sp_ff == SP_W'(1));
   assign stat.rsp_full   = rsp_valid_ff;

   // edge matrix read port
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = prev_link_ff;
      if (cmd.load) begin
         rd_en = need_edge;
      end else if (cmd.root) begin
         rd_en   = 1'b1;
         rd_addr = root;
      end else if (cmd.step) begin
         rd_en   = push;
         rd_addr = w;
      end else if (cmd.pop) begin
         rd_en   = 1'b1;
         rd_addr = stk_q_ff.v;
      end
   end

   assign wr_data = row | onehot(wr_bit_ff);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         edge_q_ff   <= edge_mem[rd_addr];
         edge_vld_ff <= row_vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.edge_wr) edge_mem[wr_row_ff] <= wr_data;
   end

   // rows never written since clear read as empty
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         row_vld_ff <= '0;
      end else if (cmd.edge_wr) begin
         row_vld_ff <= row_vld_ff | onehot(wr_row_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && push) stack_mem[sp_m1[STK_AW-1:0]] <= '{v: top_v_ff, c: w_next};
   end

   always_ff @(posedge clock) begin
      if (do_pop_rd) stk_q_ff <= stack_mem[sp_m2[STK_AW-1:0]];
   end

   // route tracking
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         prev_link_ff  <= '0;
         prev_valid_ff <= 1'b0;
         sticky_ff     <= 1'b0;
      end else if (cmd.load) begin
         if (!in_range) begin
            prev_valid_ff <= 1'b0;
         end else begin
            if (prev_valid_ff && same_link) sticky_ff <= 1'b1;
            prev_link_ff  <= req_link;
            prev_valid_ff <= (req_func == FUNC_LINK);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         wr_row_ff <= prev_link_ff;
         wr_bit_ff <= req_link;
      end
   end

   // walk state
   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff <= '0;
         on_path_ff <= '0;
         sp_ff      <= '0;
         top_v_ff   <= '0;
         top_c_ff   <= '0;
         cyc_ff     <= 1'b0;
      end else if (cmd.walk_init) begin
         visited_ff <= '0;
         on_path_ff <= '0;
         sp_ff      <= '0;
         cyc_ff     <= 1'b0;
      end else if (cmd.root) begin
         visited_ff <= visited_ff | onehot(root);
         on_path_ff <= on_path_ff | onehot(root);
         top_v_ff   <= root;
         top_c_ff   <= '0;
         sp_ff      <= SP_W'(1);
      end else if (cmd.step) begin
         if (rest_zero) begin
            on_path_ff <= on_path_ff & ~onehot(top_v_ff);
            sp_ff      <= sp_m1;
         end else if (hit) begin
            cyc_ff <= 1'b1;
         end else if (push) begin
            visited_ff <= visited_ff | onehot(w);
            on_path_ff <= on_path_ff | onehot(w);
            top_v_ff   <= w;
            top_c_ff   <= '0;
            sp_ff      <= sp_ff + SP_W'(1);
         end else begin
            top_c_ff <= w_next;
         end
      end else if (cmd.pop) begin
         top_v_ff <= stk_q_ff.v;
         top_c_ff <= stk_q_ff.c;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= cmd.finish || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_cyc_ff <= cyc_ff;
         rsp_err_ff <= sticky_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DW'({rsp_err_ff, rsp_cyc_ff});

endmodule

### rtl/channel_dependency_cycle_check_top.sv
// Top level of the channel dependency cycle check.
// Load beat: when it adds an edge, a row read, then a row write.
// Clear beat: resets route tracking and the row valid bits. Check beat: depth-first walk,
// one edge probe per cycle in the step state; the result is registered once any earlier one is taken.
// Reset is synchronous; the per-row valid bits empty the matrix at once.
module channel_dependency_cycle_check_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ccc_pkg::REQ_DW-1:0]  req_tdata,  // link_id[5:0], zero pad
   input  logic [ccc_pkg::REQ_UW-1:0]  req_tuser,  // func[1:0]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ccc_pkg::RSP_DW-1:0]  rsp_tdata   // has_cycle, repeat_error, zero pad
);
   import ccc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ccc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ccc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_link   (req_tdata[LINK_W-1:0]),
      .req_func   (req_tuser),
      .cmd        (cmd),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/ccc_check.sv
// Port-level checks for the cycle check top, bound to it.
`include "channel_dependency_cycle_check_top_macros.svh"

module ccc_check (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic [ccc_pkg::REQ_UW-1:0]  req_tuser,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [ccc_pkg::RSP_DW-1:0]  rsp_tdata
);
   import ccc_pkg::*;

   `CCC_ASSERT_NEXT_ALWAYS(a_reset_no_rsp, reset, !rsp_tvalid)
   `CCC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `CCC_ASSERT_NEXT(a_check_busy, req_tvalid && req_tready && req_tuser == FUNC_CHECK, !req_tready)
   `CCC_ASSERT_NEXT(a_clear_ready, req_tvalid && req_tready && req_tuser == FUNC_CLEAR, req_tready)

endmodule

bind channel_dependency_cycle_check_top ccc_check u_ccc_check (.*);

### dv/channel_dependency_cycle_check_top_tb.sv
// Self-checking testbench for the channel dependency cycle check top level.
module channel_dependency_cycle_check_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ccc_pkg::*;

   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic has_cycle;
      logic repeat_error;
   } verdict_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata  = '0;
   logic [REQ_UW-1:0] req_tuser  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;

   row_type     link_graph [NUM_LINKS];
   link_type    route_prev;
   bit          route_open;
   bit          repeat_seen;
   verdict_type pending_verdicts [$];

   bit quiet;
   int beats_sent;
   int errors;
   int idle_cycles;

   channel_dependency_cycle_check_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 48);
   endfunction

   // graph is cyclic iff repeated sink pruning leaves vertices behind
   function automatic bit graph_has_cycle();
      row_type alive;
      bit      pruned;
      alive = '1;
      do begin
         pruned = 1'b0;
         for (int v = 0; v < NUM_LINKS; v++) begin
            if (alive[v] && (link_graph[v] & alive) == '0) begin
               alive[v] = 1'b0;
               pruned   = 1'b1;
            end
         end
      end while (pruned);
      return alive != '0;
   endfunction

   function automatic void clear_graph();
      foreach (link_graph[v]) link_graph[v] = '0;
      route_prev  = '0;
      route_open  = 1'b0;
      repeat_seen = 1'b0;
   endfunction

   function automatic void update_graph(func_type f, link_type l);
      verdict_type vd;
      case (f)
         FUNC_CHECK: begin
            vd.has_cycle    = graph_has_cycle();
            vd.repeat_error = repeat_seen;
            pending_verdicts.insert(pending_verdicts.size(), vd);
         end
         FUNC_CLEAR: begin
            clear_graph();
         end
         default: begin
            if (int'(l) >= NUM_LINKS) begin
               route_open = 1'b0;
            end else begin
               if (route_open) begin
                  if (route_prev == l) repeat_seen = 1'b1;
                  else link_graph[route_prev][l] = 1'b1;
               end
               route_prev = l;
               route_open = (f == FUNC_LINK);
            end
         end
      endcase
   endfunction

   // called on a rising edge; returns on the edge the beat is taken
   task automatic send_beat(input func_type f, input link_type l);
      int n;
      n = pick_gap();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= REQ_DW'(l);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      update_graph(f, l);
      beats_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_beat(FUNC_CHECK, 6'd0);
      send_beat(FUNC_LINK,  6'd0);
      send_beat(FUNC_END,   6'd63);
      send_beat(FUNC_CHECK, 6'd63);
      send_beat(FUNC_LINK,  6'd63);
      send_beat(FUNC_END,   6'd0);
      send_beat(FUNC_CHECK, 6'd0);
      send_beat(FUNC_CLEAR, 6'd63);
      send_beat(FUNC_CHECK, 6'd0);
      // repeated link sets the sticky flag, route carries on from it
      send_beat(FUNC_LINK,  6'd5);
      send_beat(FUNC_LINK,  6'd5);
      send_beat(FUNC_END,   6'd6);
      send_beat(FUNC_CHECK, 6'd0);
      send_beat(FUNC_LINK,  6'd42);
      send_beat(FUNC_LINK,  6'd21);
      send_beat(FUNC_END,   6'd42);
      send_beat(FUNC_CHECK, 6'd21);
      send_beat(FUNC_CLEAR, 6'd0);
      send_beat(FUNC_CHECK, 6'd0);
      send_beat(FUNC_END,   6'd7);
      send_beat(FUNC_CHECK, 6'd0);
      // check mid-route leaves the route open
      send_beat(FUNC_LINK,  6'd1);
      send_beat(FUNC_CHECK, 6'd0);
      send_beat(FUNC_END,   6'd2);
      send_beat(FUNC_CHECK, 6'd0);
   endtask

   task automatic test_long_chain();
      send_beat(FUNC_CLEAR, 6'd0);
      for (int i = 0; i < NUM_LINKS; i++)
         send_beat((i == NUM_LINKS - 1) ? FUNC_END : FUNC_LINK, link_type'(i));
      send_beat(FUNC_CHECK, 6'd0);
      send_beat(FUNC_LINK,  6'd63);
      send_beat(FUNC_END,   6'd0);
      send_beat(FUNC_CHECK, 6'd0);
      send_beat(FUNC_CLEAR, 6'd0);
      send_beat(FUNC_CHECK, 6'd0);
   endtask

   task automatic test_random_routes(input int beats);
      int       stop;
      int       len;
      int       kind;
      int       base;
      link_type l;
      link_type last;
      stop = beats_sent + beats;
      last = '0;
      while (beats_sent < stop) begin
         kind = $urandom_range(0, 9);
         len  = $urandom_range(1, 8);
         base = $urandom_range(0, 63);
         for (int i = 0; i < len; i++) begin
            if (i > 0 && $urandom_range(0, 19) == 0) l = last;
            else if (kind < 4) l = link_type'(base + $urandom_range(0, 7));
            else if (kind < 7) l = (i == 0) ? link_type'(base)
                                            : link_type'(last + $urandom_range(1, 5));
            else l = link_type'($urandom_range(0, 63));
            // stray beat breaking into the route
            if ($urandom_range(0, 24) == 0)
               send_beat(func_type'($urandom_range(0, 3)), link_type'($urandom_range(0, 63)));
            send_beat((i == len - 1) ? FUNC_END : FUNC_LINK, l);
            last = l;
         end
         if ($urandom_range(0, 2) == 0)
            send_beat(FUNC_CHECK, link_type'($urandom_range(0, 63)));
         if ($urandom_range(0, 14) == 0) begin
            send_beat(FUNC_CHECK, link_type'($urandom_range(0, 63)));
            send_beat(FUNC_CLEAR, link_type'($urandom_range(0, 63)));
         end
      end
   endtask

   task automatic test_drained_pause();
      test_random_routes(60);
      send_beat(FUNC_CHECK, 6'd0);
      wait_drained();
      test_random_routes(60);
   endtask

   task automatic test_back_to_back();
      quiet = 1'b1;
      test_random_routes(200);
      quiet = 1'b0;
   endtask

   initial begin : rsp_ready_gen
      int n;
      @(posedge clock);
      forever begin
         n = pick_gap();
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : verdict_check
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected result beat, data %02h", $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_tdata[0] !== want.has_cycle) begin
               $display("%0t: has_cycle expected %0b, got %0b",
                        $time, want.has_cycle, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[1] !== want.repeat_error) begin
               $display("%0t: repeat_error expected %0b, got %0b",
                        $time, want.repeat_error, rsp_tdata[1]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clear_graph();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_long_chain();
      test_random_routes(700);
      test_drained_pause();
      test_back_to_back();
      test_random_routes(700);
      wait_drained();
      repeat (200) @(posedge clock);
      if (errors == 0 && pending_verdicts.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
